// ----- hdl/dts_pkg.sv -----
// Shared types and constants for the descending tagged sorter.
`timescale 1ns / 1ps
package dts_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned TAG_W    = 8;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic        [TAG_W-1:0]   tag;
  } slot_t;

endpackage

// ----- hdl/descending_tagged_sorter_unit.sv -----
// Top level of the descending tagged sorter: insertion chain plus sequencer.
//
// Loads up to CAPACITY (16) value/tag beats, one per cycle, each inserted as it is
// accepted into a chain of cells that keeps the set ordered highest value
// first; equal values keep arrival order. The beat marked final_item_i starts
// the drain: the chain shifts toward cell 0 and one result leaves per cycle
// while out_ready_i is high, the last one flagged with run_end_o. Input is held
// off (in_ready_o low) during the drain. Beats arriving with the chain full
// are dropped and overflowed_o is high on every result of that set.
`timescale 1ns / 1ps
module descending_tagged_sorter_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [dts_pkg::VALUE_W-1:0] sale_cents_i,
  input  logic        [dts_pkg::TAG_W-1:0]   tag_i,
  input  logic                               final_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [dts_pkg::VALUE_W-1:0] sorted_cents_o,
  output logic        [dts_pkg::TAG_W-1:0]   sorted_tag_o,
  output logic                               run_end_o,
  output logic                               overflowed_o
);
  import dts_pkg::*;

  cell_ctrl_t cell_ctrl;
  slot_t      slot   [CAPACITY];
  logic       keep   [CAPACITY];
  slot_t      empty_slot;
  logic       full;

  assign empty_slot.valid = 1'b0;
  assign empty_slot.value = '0;
  assign empty_slot.tag   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t prev_slot, next_slot;
    logic  prev_keep;

    if (i == 0) begin : g_head
      assign prev_slot = empty_slot;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_slot = slot[i-1];
      assign prev_keep = keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_slot = empty_slot;
    end else begin : g_inner
      assign next_slot = slot[i+1];
    end

    dts_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .new_value_i(sale_cents_i),
      .new_tag_i  (tag_i),
      .prev_slot_i(prev_slot),
      .prev_keep_i(prev_keep),
      .next_slot_i(next_slot),
      .slot_o     (slot[i]),
      .keep_o     (keep[i])
    );
  end

  assign full      = slot[CAPACITY-1].valid;
  assign run_end_o = slot[0].valid && !slot[1].valid;

  dts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .final_item_i(final_item_i),
    .full_i      (full),
    .out_ready_i (out_ready_i),
    .run_end_i   (run_end_o),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .overflow_o  (overflowed_o),
    .ctrl_o      (cell_ctrl)
  );

  assign sorted_cents_o = slot[0].value;
  assign sorted_tag_o   = slot[0].tag;

endmodule

// ----- hdl/dts_cell.sv -----
// One slot of the insertion chain: holds a value/tag pair, takes new, left or right data.
`timescale 1ns / 1ps
module dts_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dts_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [dts_pkg::VALUE_W-1:0] new_value_i,
  input  logic        [dts_pkg::TAG_W-1:0]   new_tag_i,
  input  dts_pkg::slot_t                    prev_slot_i,
  input  logic                              prev_keep_i,
  input  dts_pkg::slot_t                    next_slot_i,
  output dts_pkg::slot_t                    slot_o,
  output logic                              keep_o
);
  import dts_pkg::*;

  logic                      valid_q, valid_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic        [TAG_W-1:0]   tag_q, tag_d;

  // keep: stored pair ranks ahead of (or ties with) the incoming one
  assign keep_o = valid_q && (value_q >= new_value_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    tag_d   = tag_q;
    if (ctrl_i.insert) begin
      if (!keep_o) begin
        if (prev_keep_i) begin
          valid_d = 1'b1;
          value_d = new_value_i;
          tag_d   = new_tag_i;
        end else begin
          valid_d = prev_slot_i.valid;
          value_d = prev_slot_i.value;
          tag_d   = prev_slot_i.tag;
        end
      end
    end else if (ctrl_i.shift) begin
      valid_d = next_slot_i.valid;
      value_d = next_slot_i.value;
      tag_d   = next_slot_i.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    tag_q   <= tag_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.value = value_q;
  assign slot_o.tag   = tag_q;

endmodule

// ----- hdl/dts_ctrl.sv -----
// Load/drain sequencer and overflow flag for the sorter chain.
`timescale 1ns / 1ps
module dts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                final_item_i,
  input  logic                full_i,
  input  logic                out_ready_i,
  input  logic                run_end_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output logic                overflow_o,
  output dts_pkg::cell_ctrl_t ctrl_o
);
  import dts_pkg::*;

  state_e state_q, state_d;
  logic   overflow_q, overflow_d;
  logic   in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire && final_item_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_fire && run_end_i) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD:  in_ready_o  = 1'b1;
      ST_DRAIN: out_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign ctrl_o.insert = in_fire && !full_i;
  assign ctrl_o.shift  = out_fire;

  always_comb begin
    overflow_d = overflow_q;
    if (in_fire && full_i) overflow_d = 1'b1;
    else if (out_fire && run_end_i) overflow_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

  assign overflow_o = overflow_q;

endmodule

// ----- hdl/dts_checker.sv -----
// Port-level checks for the descending tagged sorter, bound to the top level.
`timescale 1ns / 1ps
module dts_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic final_item_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic run_end_o
);

  a_no_load_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while draining");

  a_final_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && final_item_i |=> out_valid_o)
    else $error("final beat did not start output");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_end_o |=> out_valid_o)
    else $error("run stopped before run_end");

  a_run_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && run_end_o |=> !out_valid_o && in_ready_o)
    else $error("output continued after run_end");

endmodule

bind descending_tagged_sorter_unit dts_checker u_dts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .final_item_i(final_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .run_end_o   (run_end_o)
);

// ----- tb/tb_descending_tagged_sorter_unit.sv -----
// Testbench for the descending tagged sorter: random sets, stalls, stable-order scoreboard.
`timescale 1ns / 1ps
module tb_descending_tagged_sorter_unit;
  import dts_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] cents;
    logic        [TAG_W-1:0]   tag;
    logic                      last;
  } sale_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] cents;
    logic        [TAG_W-1:0]   tag;
    logic                      run_end;
    logic                      overflowed;
  } sorted_entry_t;

  localparam int RANDOM_BEATS = 340;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [VALUE_W-1:0] sale_cents = '0;
  logic [TAG_W-1:0] tag = '0;
  logic final_item = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VALUE_W-1:0] sorted_cents;
  logic [TAG_W-1:0] sorted_tag;
  logic run_end;
  logic overflowed;

  sale_beat_t    pending_beats[$];
  sorted_entry_t expected_sorted_q[$];

  logic signed [VALUE_W-1:0] held_cents[CAPACITY];
  logic [TAG_W-1:0] held_tags[CAPACITY];
  int held_count = 0;
  logic held_overflow = 1'b0;

  int errors = 0;
  int beats_sent = 0;
  int total_beats = 0;
  int sets_sorted = 0;
  int overflow_sets = 0;
  int results_checked = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int random_beats = 0;
  int set_len;
  sale_beat_t next_beat;
  sorted_entry_t head;

  descending_tagged_sorter_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sale_cents_i   (sale_cents),
    .tag_i          (tag),
    .final_item_i   (final_item),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sorted_cents_o (sorted_cents),
    .sorted_tag_o   (sorted_tag),
    .run_end_o      (run_end),
    .overflowed_o   (overflowed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_cents();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 7) return $signed($urandom_range(0, 16)) - 8;
    if (r == 7) return {1'b0, {(VALUE_W-1){1'b1}}};
    if (r == 8) return {1'b1, {(VALUE_W-1){1'b0}}};
    return $signed($urandom_range(0, 200000)) - 100000;
  endfunction

  task automatic add_beat(input logic signed [VALUE_W-1:0] cents,
                          input logic [TAG_W-1:0] lbl, input logic last);
    sale_beat_t b;
    b.cents = cents;
    b.tag   = lbl;
    b.last  = last;
    pending_beats.push_back(b);
  endtask

  // Stable descending insert; a full store drops the beat but a final mark still drains.
  task automatic sort_insert(input logic signed [VALUE_W-1:0] cents,
                             input logic [TAG_W-1:0] lbl, input logic last);
    int pos;
    int k;
    sorted_entry_t e;
    if (held_count < CAPACITY) begin
      pos = 0;
      while (pos < held_count && held_cents[pos] >= cents) pos++;
      for (k = held_count; k > pos; k--) begin
        held_cents[k] = held_cents[k-1];
        held_tags[k]  = held_tags[k-1];
      end
      held_cents[pos] = cents;
      held_tags[pos]  = lbl;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (last) begin
      for (k = 0; k < held_count; k++) begin
        e.cents      = held_cents[k];
        e.tag        = held_tags[k];
        e.run_end    = (k == held_count - 1);
        e.overflowed = held_overflow;
        expected_sorted_q.push_back(e);
      end
      sets_sorted++;
      if (held_overflow) overflow_sets++;
      held_count = 0;
      held_overflow = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1'b1;
    end else begin
      if (in_valid) beats_sent++;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        sale_cents <= next_beat.cents;
        tag <= next_beat.tag;
        final_item <= next_beat.last;
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) sort_insert(sale_cents, tag, final_item);
      if (out_valid && out_ready) begin
        if (expected_sorted_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result cents %0d tag %0d", $time, sorted_cents,
                   sorted_tag);
        end else begin
          head = expected_sorted_q.pop_front();
          check_field("sorted_cents", head.cents, sorted_cents);
          check_field("sorted_tag", head.tag, sorted_tag);
          check_field("run_end", head.run_end, run_end);
          check_field("overflowed", head.overflowed, overflowed);
          results_checked++;
        end
      end
      if (recv_stall > 0) recv_stall--;
      else if ($urandom_range(0, 99) < 20) recv_stall = pick_gap();
      out_ready <= (recv_stall == 0);
    end
  end

  initial begin
    // single-beat sets at both extremes
    add_beat({1'b1, {(VALUE_W-1){1'b0}}}, 8'h00, 1'b1);
    add_beat({1'b0, {(VALUE_W-1){1'b1}}}, 8'hff, 1'b1);
    // ties must keep arrival order
    add_beat(32'sd500, 8'd1, 1'b0);
    add_beat(-32'sd1, 8'd2, 1'b0);
    add_beat(32'sd500, 8'd3, 1'b0);
    add_beat(32'sd0, 8'd4, 1'b0);
    add_beat(32'sd500, 8'd5, 1'b1);
    // fill to capacity, then a dropped beat that also carries the final mark
    for (int i = 0; i < CAPACITY; i++)
      add_beat(pick_cents(), 8'(i * 17), 1'b0);
    add_beat(32'sd7, 8'haa, 1'b1);

    while (random_beats < RANDOM_BEATS) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(CAPACITY + 1, CAPACITY + 8)
                                           : $urandom_range(1, CAPACITY);
      for (int i = 0; i < set_len; i++)
        add_beat(pick_cents(), 8'($urandom_range(0, 255)), i == set_len - 1);
      random_beats += set_len;
    end
    total_beats = pending_beats.size();

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    do @(negedge clk);
    while (beats_sent < total_beats || expected_sorted_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats in %0d sets (%0d overflowing); checked %0d sorted results.",
             beats_sent, sets_sorted, overflow_sets, results_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results still expected.", expected_sorted_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- descending_tagged_sorter_unit.f -----
hdl/dts_pkg.sv
hdl/dts_cell.sv
hdl/dts_ctrl.sv
hdl/descending_tagged_sorter_unit.sv
hdl/dts_checker.sv
tb/tb_descending_tagged_sorter_unit.sv
